// ----- src/sparse_vector_merge_add_core_macros.svh -----
// Assertion macros for the sparse vector merge-add core
`ifndef SPARSE_VECTOR_MERGE_ADD_CORE_MACROS_SVH
`define SPARSE_VECTOR_MERGE_ADD_CORE_MACROS_SVH
// implication checked every clock outside reset
`define SVMA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// next-cycle implication outside reset
`define SVMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- src/svma_pkg.sv -----
// Shared types, codes and float adder for the sparse vector merge-add core
package svma_pkg;
   localparam int LIST_DEPTH = 32;
   localparam int PTR_W = $clog2(LIST_DEPTH);
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int MCNT_W = 7;
   localparam logic [31:0] QNAN = 32'h7FC0_0000;

   typedef enum logic [1:0] {
      KIND_LOAD_A = 2'd0,
      KIND_LOAD_B = 2'd1,
      KIND_START  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_DECIDE, ST_ADD, ST_EMIT
   } state_type;

   // head selection for one merge step
   typedef enum logic [1:0] {
      SEL_A = 2'd0, SEL_B = 2'd1, SEL_BOTH = 2'd2, SEL_EMPTY = 2'd3
   } sel_type;

   typedef struct packed {
      logic     load_a;
      logic     load_b;
      logic     clear;
      logic     read;
      logic     decide;
      logic     add;
      logic     emit;
   } cmd_type;

   typedef struct packed {
      logic     a_left;
      logic     b_left;
      logic     rsp_free;
      logic     last;
   } sts_type;

   // align stage: swap, align and give 27-bit magnitudes
   typedef struct packed {
      logic        special;
      logic [31:0] spec_val;
      logic        sign;
      logic        same;
      logic [7:0]  e;
      logic [26:0] ma;
      logic [26:0] mb;
   } fadd_mid_type;

   function automatic fadd_mid_type fadd_align(input logic [31:0] a, input logic [31:0] b);
      fadd_mid_type r;
      logic sa, sb, ts;
      logic [7:0] ea, eb, te, d;
      logic [26:0] ma, mb, tm, mask;
      r = '0;
      sa = a[31]; sb = b[31];
      ea = a[30:23]; eb = b[30:23];
      ma = {1'b0, a[22:0], 3'b0};
      mb = {1'b0, b[22:0], 3'b0};
      if ((ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0)) begin
         r.special = 1'b1; r.spec_val = QNAN;
      end else if (ea == 8'hFF) begin
         r.special = 1'b1;
         r.spec_val = (eb == 8'hFF && sa != sb) ? QNAN : a;
      end else if (eb == 8'hFF) begin
         r.special = 1'b1; r.spec_val = b;
      end
      if (ea == 0) ea = 8'd1; else ma[26] = 1'b1;
      if (eb == 0) eb = 8'd1; else mb[26] = 1'b1;
      if (eb > ea || (eb == ea && mb > ma)) begin
         te = ea; ea = eb; eb = te;
         tm = ma; ma = mb; mb = tm;
         ts = sa; sa = sb; sb = ts;
      end
      d = ea - eb;
      if (d >= 8'd27) mb = {26'b0, |mb};
      else if (d != 0) begin
         mask = (27'd1 << d[4:0]) - 27'd1;
         mb = (mb >> d[4:0]) | {26'b0, |(mb & mask)};
      end
      r.sign = sa; r.same = (sa == sb); r.e = ea; r.ma = ma; r.mb = mb;
      return r;
   endfunction

   // add/subtract, normalise and round
   function automatic logic [31:0] fadd_finish(input fadd_mid_type p);
      logic [27:0] m;
      logic [9:0]  e;
      logic [4:0]  lz;
      logic [2:0]  g;
      logic [24:0] mr;
      logic [31:0] r;
      r = '0;
      e = {2'b0, p.e};
      lz = '0;
      if (p.same) m = {1'b0, p.ma} + {1'b0, p.mb};
      else m = {1'b0, p.ma} - {1'b0, p.mb};
      if (p.special) r = p.spec_val;
      else if (m == 0) r = p.same ? {p.sign, 31'b0} : 32'b0;
      else begin
         if (m[27]) begin
            m = {1'b0, m[27:2], m[1] | m[0]};
            e = e + 10'd1;
         end else if (!p.same) begin
            // leading-zero count, clamped so exponent stays at least one
            for (int i = 26; i >= 0; i--)
               if (m[i] && lz == 0 && !m[26]) lz = 5'(26 - i);
            if ({5'b0, lz} >= e) lz = 5'(e - 10'd1);
            m = m << lz;
            e = e - {5'b0, lz};
         end
         g = m[2:0];
         mr = {1'b0, m[26:3]};
         if (g > 3'd4 || (g == 3'd4 && mr[0])) mr = mr + 25'd1;
         if (mr[24]) begin
            mr = mr >> 1;
            e = e + 10'd1;
         end
         if (e >= 10'd255) r = {p.sign, 8'hFF, 23'b0};
         else r = {p.sign, (mr[23] ? e[7:0] : 8'd0), mr[22:0]};
      end
      return r;
   endfunction
endpackage

// ----- src/svma_ctrl.sv -----
// Controller state machine for the sparse vector merge-add core
module svma_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [1:0]       req_kind,
   input  svma_pkg::sts_type sts,
   output svma_pkg::cmd_type cmd
);
   import svma_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_a = (req_kind == KIND_LOAD_A);
               cmd.load_b = (req_kind == KIND_LOAD_B);
               if (req_kind == KIND_START) state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               if (sts.last) begin
                  cmd.clear = 1'b1;
                  state_in = ST_IDLE;
               end else state_in = ST_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ----- src/svma_dp.sv -----
// Datapath: list memories, head compare, float adder and result register
module svma_dp (
   input  logic               clock,
   input  logic               reset,
   input  logic [31:0]        req_index,
   input  logic [31:0]        req_value,
   input  svma_pkg::cmd_type  cmd,
   output svma_pkg::sts_type  sts,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [79:0]        rsp_tdata,
   output logic               rsp_tlast
);
   import svma_pkg::*;

   logic [63:0] mem_a [LIST_DEPTH];
   logic [63:0] mem_b [LIST_DEPTH];
   logic [63:0] rd_a_ff, rd_b_ff;
   logic [CNT_W-1:0] cnt_a_ff, cnt_b_ff, pa_ff, pb_ff, pa_in, pb_in;
   logic [MCNT_W-1:0] k_ff;
   logic ovf_ff;
   sel_type sel_ff, sel_in;
   fadd_mid_type mid_ff;
   logic [31:0] res_idx_ff, res_val_ff;
   logic last_ff, last_in;
   logic rv_ff, rlast_ff, rempty_ff, rovf_ff;
   logic [MCNT_W-1:0] rcnt_ff;
   logic [31:0] oidx_ff, oval_ff;
   logic a_left, b_left;

   assign a_left = pa_ff < cnt_a_ff;
   assign b_left = pb_ff < cnt_b_ff;

   // list memories
   always_ff @(posedge clock) begin
      if (cmd.load_a && cnt_a_ff < CNT_W'(LIST_DEPTH))
         mem_a[cnt_a_ff[PTR_W-1:0]] <= {req_index, req_value};
      if (cmd.load_b && cnt_b_ff < CNT_W'(LIST_DEPTH))
         mem_b[cnt_b_ff[PTR_W-1:0]] <= {req_index, req_value};
      if (cmd.read) begin
         rd_a_ff <= mem_a[pa_ff[PTR_W-1:0]];
         rd_b_ff <= mem_b[pb_ff[PTR_W-1:0]];
      end
   end

   // head decision
   always_comb begin
      sel_in = SEL_EMPTY;
      pa_in = pa_ff;
      pb_in = pb_ff;
      priority if (a_left && b_left) begin
         if (rd_a_ff[63:32] < rd_b_ff[63:32]) sel_in = SEL_A;
         else if (rd_a_ff[63:32] > rd_b_ff[63:32]) sel_in = SEL_B;
         else sel_in = SEL_BOTH;
      end else if (a_left) sel_in = SEL_A;
      else if (b_left) sel_in = SEL_B;
      if (sel_in == SEL_A || sel_in == SEL_BOTH) pa_in = pa_ff + CNT_W'(1);
      if (sel_in == SEL_B || sel_in == SEL_BOTH) pb_in = pb_ff + CNT_W'(1);
      last_in = !(pa_in < cnt_a_ff) && !(pb_in < cnt_b_ff);
   end

   // counters, pointers and decision registers
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         cnt_a_ff <= '0; cnt_b_ff <= '0; ovf_ff <= 1'b0;
         pa_ff <= '0; pb_ff <= '0; k_ff <= '0;
      end else begin
         if (cmd.load_a) begin
            if (cnt_a_ff < CNT_W'(LIST_DEPTH)) cnt_a_ff <= cnt_a_ff + CNT_W'(1);
            else ovf_ff <= 1'b1;
         end
         if (cmd.load_b) begin
            if (cnt_b_ff < CNT_W'(LIST_DEPTH)) cnt_b_ff <= cnt_b_ff + CNT_W'(1);
            else ovf_ff <= 1'b1;
         end
         if (cmd.decide) begin
            pa_ff <= pa_in; pb_ff <= pb_in;
            k_ff <= k_ff + MCNT_W'(1);
         end
      end
      if (cmd.decide) begin
         sel_ff <= sel_in;
         last_ff <= last_in;
         mid_ff <= fadd_align(rd_a_ff[31:0], rd_b_ff[31:0]);
         res_idx_ff <= (sel_in == SEL_B) ? rd_b_ff[63:32] : rd_a_ff[63:32];
      end
      if (cmd.add) begin
         unique case (sel_ff)
            SEL_A:    res_val_ff <= rd_a_ff[31:0];
            SEL_B:    res_val_ff <= rd_b_ff[31:0];
            SEL_BOTH: res_val_ff <= fadd_finish(mid_ff);
            SEL_EMPTY: begin
               res_val_ff <= '0;
               res_idx_ff <= '0;
            end
            default:  res_val_ff <= '0;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (cmd.emit) rv_ff <= 1'b1;
      else if (rsp_tready) rv_ff <= 1'b0;
      if (cmd.emit) begin
         oidx_ff <= res_idx_ff;
         oval_ff <= res_val_ff;
         rlast_ff <= last_ff;
         rempty_ff <= (sel_ff == SEL_EMPTY);
         rcnt_ff <= (last_ff && sel_ff != SEL_EMPTY) ? k_ff : '0;
         rovf_ff <= ovf_ff;
      end
   end

   assign sts.a_left = a_left;
   assign sts.b_left = b_left;
   assign sts.rsp_free = !rv_ff || rsp_tready;
   assign sts.last = last_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tlast = rlast_ff;
   assign rsp_tdata = {7'b0, rovf_ff, rcnt_ff, rempty_ff, oval_ff, oidx_ff};
endmodule

// ----- src/sparse_vector_merge_add_core.sv -----
// Top level of the sparse vector merge-add core
//  channel | dir | tdata (low bit up)                          | tuser | tlast
//  req     | in  | entry_index[31:0], entry_value[63:32]       | kind  | -
//  rsp     | out | out_index[31:0], out_value[63:32], out_empty[64],
//          |     | merged_count[71:65], overflow_seen[72], zero[79:73] | - | out_last
// Loads are accepted back to back while idle. A merge steps the controller
// through four states for every merged entry (memory read, head compare with
// float align, float add and round, output register). Reset is synchronous and
// clears counts and flags; the list memories keep no reset. A stalled result
// holds the merge in place.
module sparse_vector_merge_add_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // entry_index, entry_value
   input  logic [1:0]  req_tuser,  // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,  // out_index, out_value, out_empty, merged_count, overflow_seen
   output logic        rsp_tlast   // out_last
);
   import svma_pkg::*;

   cmd_type cmd;
   sts_type sts;

   svma_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_kind(req_tuser), .sts, .cmd
   );

   svma_dp u_dp (
      .clock, .reset,
      .req_index(req_tdata[31:0]), .req_value(req_tdata[63:32]),
      .cmd, .sts,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );
endmodule

// ----- src/svma_checker.sv -----
// Port-level checker for the sparse vector merge-add core
`include "sparse_vector_merge_add_core_macros.svh"
module svma_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tlast
);
   `SVMA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `SVMA_ASSERT_IMPL(a_empty_last, clock, reset, rsp_tvalid && rsp_tdata[64], rsp_tlast)
   `SVMA_ASSERT_IMPL(a_cnt_last, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tdata[71:65] == 7'd0)
   `SVMA_ASSERT_IMPL(a_no_take, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready)
endmodule

bind sparse_vector_merge_add_core svma_checker u_svma_checker (.*);
